/* hw/rtl/psf_pkg.sv */
package psf_pkg;

  localparam int MaxPatternBytes = 16;
  localparam int CfgDataW        = 32;
  localparam int CfgIdxW         = 3;
  localparam int LenW            = 5;
  localparam int CountW          = 48;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatWord0 = 3'd0,
    CfgPatWord1 = 3'd1,
    CfgPatWord2 = 3'd2,
    CfgPatWord3 = 3'd3,
    CfgPatLen   = 3'd4
  } psf_cfg_idx_e;

  typedef enum logic {
    OpByte  = 1'b0,
    OpClear = 1'b1
  } psf_op_e;

  typedef enum logic [1:0] {
    StatusFound   = 2'd0,
    StatusDrop    = 2'd1,
    StatusDropped = 2'd2
  } psf_status_e;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       already_dropped;
  } psf_in_t;

  typedef struct packed {
    logic [1:0]        packet_status;
    logic [CountW-1:0] match_count;
  } psf_out_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } psf_cfg_wr_t;

  typedef struct packed {
    logic advance;
    logic flush;
  } psf_cell_ctrl_t;

endpackage

/* hw/rtl/psf_cell.sv */
module psf_cell #(
  parameter int CellIdx = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  psf_pkg::psf_cfg_wr_t   cfg_i,
  input  psf_pkg::psf_cell_ctrl_t ctrl_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   prev_bit_i,
  output logic                   match_o,
  output logic                   bit_o
);
  import psf_pkg::*;

  localparam int WordIdx = CellIdx / 4;
  localparam int Lane    = CellIdx % 4;

  logic [7:0] pat_q;
  logic       bit_q;
  logic       bit_d;

  // Extend the run handed over by the left neighbor if this byte matches.
  assign match_o = prev_bit_i & (data_byte_i == pat_q);
  assign bit_d   = ctrl_i.flush ? 1'b0 : match_o;
  assign bit_o   = bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= 8'h00;
    end else if (cfg_i.we && (cfg_i.idx == CfgIdxW'(CfgPatWord0 + WordIdx))) begin
      pat_q <= cfg_i.data[Lane*8 +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else if (ctrl_i.advance) begin
      bit_q <= bit_d;
    end
  end

endmodule

/* hw/rtl/packet_substring_filter_core.sv */
// Packet substring filter.
// Input beats carry one packet byte each (op = byte) or a counter clear
// (op = clear). A beat is taken on a clock edge with in_valid_i high and
// in_stall_o low; one beat can be taken every cycle.
// On the last byte of a packet one result beat is registered for the
// output channel (in the skid register if the output is held): status
// (found / not found / dropped upstream) and the saturating count of
// kept packets after this packet. Other beats give no result.
// Matching runs in a row of byte cells, one per pattern byte; each cell
// compares the incoming byte to its pattern byte and passes its partial
// match bit to the next cell, so every byte is checked in all cells at once.
// The output has a register plus a skid register: input beats keep
// flowing while a result waits, and in_stall_o rises only once both are
// full under out_stall_i.
// Pattern words and length are written through cfg_we_i / cfg_idx_i /
// cfg_data_i while no packet is in flight. Reset clears the pattern,
// length, partial matches, counter and both output valid flags.
module packet_substring_filter_core #(
  parameter int MaxPatternBytes = psf_pkg::MaxPatternBytes
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [psf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [psf_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  psf_pkg::psf_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output psf_pkg::psf_out_t              out_data_o
);
  import psf_pkg::*;

  logic [LenW-1:0]            len_q;
  logic [LenW-1:0]            used_len;
  logic [MaxPatternBytes-1:0] match_now;
  logic [MaxPatternBytes-1:0] chain_bits;
  logic [MaxPatternBytes-1:0] len_sel;
  logic                       found_q, found_d, found_now;
  logic [CountW-1:0]          cnt_q, cnt_d;
  logic                       in_acc, advance, is_last, res_valid;
  psf_out_t                   res;
  psf_cfg_wr_t                cfg_wr;
  psf_cell_ctrl_t             cell_ctrl;
  logic                       main_valid_q, main_valid_d;
  logic                       skid_valid_q, skid_valid_d;
  psf_out_t                   main_q, main_d;
  psf_out_t                   skid_q, skid_d;
  logic                       pop;

  assign in_acc  = in_valid_i & ~in_stall_o;
  assign advance = in_acc & (in_data_i.op == OpByte);
  assign is_last = advance & in_data_i.last_byte;

  assign cfg_wr.we   = cfg_we_i;
  assign cfg_wr.idx  = cfg_idx_i;
  assign cfg_wr.data = cfg_data_i;

  assign cell_ctrl.advance = advance;
  assign cell_ctrl.flush   = in_data_i.last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == CfgPatLen)) begin
      len_q <= cfg_data_i[LenW-1:0];
    end
  end

  assign used_len = (len_q > LenW'(MaxPatternBytes)) ? LenW'(MaxPatternBytes) : len_q;

  for (genvar g = 0; g < MaxPatternBytes; g++) begin : g_cell
    logic prev_bit;
    if (g == 0) begin : g_head
      assign prev_bit = 1'b1;
    end else begin : g_link
      assign prev_bit = chain_bits[g-1];
    end

    assign len_sel[g] = (used_len == LenW'(g + 1));

    psf_cell #(
      .CellIdx (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_i       (cfg_wr),
      .ctrl_i      (cell_ctrl),
      .data_byte_i (in_data_i.data_byte),
      .prev_bit_i  (prev_bit),
      .match_o     (match_now[g]),
      .bit_o       (chain_bits[g])
    );
  end

  assign found_now = found_q | (used_len == '0) | (|(match_now & len_sel));
  assign found_d   = in_data_i.last_byte ? 1'b0 : found_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (advance) begin
      found_q <= found_d;
    end
  end

  // Count kept packets, saturate at all ones; a clear beat resets the count.
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && (in_data_i.op == OpClear)) begin
      cnt_d = '0;
    end else if (is_last && !in_data_i.already_dropped && found_now && (cnt_q != '1)) begin
      cnt_d = cnt_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    res.match_count = cnt_d;
    if (in_data_i.already_dropped) begin
      res.packet_status = StatusDropped;
    end else if (found_now) begin
      res.packet_status = StatusFound;
    end else begin
      res.packet_status = StatusDrop;
    end
  end

  assign res_valid = is_last;

  // Output register with skid: the skid only fills when the output is held.
  assign pop        = main_valid_q & ~out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_comb begin
    main_valid_d = main_valid_q;
    main_d       = main_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!main_valid_q || pop) begin
      if (skid_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = res_valid;
        main_d       = res;
      end
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule
